@@ design/tole_pkg.sv @@
// Package: shared types, codes and constants of the TCP option label extractor.
`timescale 1ns / 1ps

package tole_pkg;

	localparam int unsigned MAX_OPTION_AREA = 40;
	localparam logic [7:0] LABEL_KIND_RESET = 8'd83;
	localparam logic [7:0] KIND_END = 8'd0;
	localparam logic [7:0] KIND_NOP = 8'd1;
	localparam logic [7:0] LABEL_OPT_LEN = 8'd6;
	localparam logic [7:0] MIN_OPT_LEN = 8'd2;
	localparam logic [1:0] LABEL_LAST_BYTE = 2'd3;
	localparam logic [5:0] AREA_MAX = 6'(MAX_OPTION_AREA);

	localparam logic [2:0] ST_FOUND = 3'd0;
	localparam logic [2:0] ST_EOL = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED = 3'd2;
	localparam logic [2:0] ST_SILLY = 3'd3;
	localparam logic [2:0] ST_PARTIAL = 3'd4;

	localparam logic [2:0] PH_DONE = 3'd0;
	localparam logic [2:0] PH_KIND = 3'd1;
	localparam logic [2:0] PH_LEN = 3'd2;
	localparam logic [2:0] PH_SKIP = 3'd3;
	localparam logic [2:0] PH_LABEL = 3'd4;

	typedef struct packed {
		logic [7:0] option_byte;
		logic       first_of_segment;
		logic [5:0] area_length;
	} in_item_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] label_value;
		logic [2:0]  parse_status;
	} result_t;

endpackage

@@ design/tole_ifs.sv @@
// Interfaces: input byte channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps

interface tole_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] option_byte;
	logic       first_of_segment;
	logic [5:0] area_length;

	modport source (output valid, output option_byte, output first_of_segment,
		output area_length, input ready);
	modport sink (input valid, input option_byte, input first_of_segment,
		input area_length, output ready);
endinterface

interface tole_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] label_value;
	logic [2:0]  parse_status;

	modport source (output valid, output label_value, output parse_status, input ready);
	modport sink (input valid, input label_value, input parse_status, output ready);
endinterface

@@ design/tcp_option_label_extractor.sv @@
// Top level: TCP option label extractor, input register, parser and result register.
`timescale 1ns / 1ps
//
// Usage:
//   option_in carries one byte of the TCP option area per transaction, with
//   first_of_segment set on a segment's first byte and area_length valid then.
//   result_out carries at most one transaction per segment, once the walk decides:
//   status plus the 4-byte label when the label option was found.
//   label_kind_we / label_kind_wdata write the option kind to match (reset 83);
//   write it only while the block is idle.
// Timing: an accepted byte is held in the input register while the parser works
//   on it; its result, if any, is registered in the result register for result_out.
// Throughput: one byte per cycle unless a byte that gives a result meets a full result
//   register; the parser's update between the input and result registers is combinational.
// Reset: clears the input register, the parser (waiting for a first byte)
//   and the result register; the label kind returns to 83.
// Stall: while a result waits, bytes that give no result still advance;
//   a byte that gives a result holds in the input register until the
//   result register frees, and option_in.ready drops meanwhile.
//

module tcp_option_label_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       label_kind_we,
	input  logic [7:0] label_kind_wdata,
	tole_in_if.sink    option_in,
	tole_out_if.source result_out
);

	logic               s1_valid_q;
	tole_pkg::in_item_t item_s1;
	logic [7:0]         label_kind_q;
	logic               out_free;
	logic               s1_adv;
	logic               in_accept;
	tole_pkg::result_t  result;

	// Hold the configured label kind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_kind_q <= tole_pkg::LABEL_KIND_RESET;
		end else if (label_kind_we) begin
			label_kind_q <= label_kind_wdata;
		end
	end

	// Advance the staged byte unless its result would overrun a waiting one.
	assign s1_adv = s1_valid_q && (!result.valid || out_free);
	assign option_in.ready = !s1_valid_q || s1_adv;
	assign in_accept = option_in.valid && option_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (option_in.ready) begin
			s1_valid_q <= option_in.valid;
		end
	end

	// Capture the payload only on an accepted transaction.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.option_byte <= option_in.option_byte;
			item_s1.first_of_segment <= option_in.first_of_segment;
			item_s1.area_length <= option_in.area_length;
		end
	end

	tole_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.label_kind (label_kind_q),
		.advance    (s1_adv),
		.item       (item_s1),
		.result     (result)
	);

	// Drop the result strobe when the staged byte does not advance.
	tole_pkg::result_t result_gated;
	always_comb begin
		result_gated = result;
		result_gated.valid = result.valid && s1_adv;
	end

	tole_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.result     (result_gated),
		.free       (out_free),
		.result_out (result_out)
	);

endmodule

@@ design/tole_parser.sv @@
// Parser: option walk state and its one-byte-per-cycle update, taken only when advance is set.
`timescale 1ns / 1ps

module tole_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          label_kind,
	input  logic                advance,
	input  tole_pkg::in_item_t  item,
	output tole_pkg::result_t   result
);

	logic [5:0]  rem_q, rem_e, rem_n, rem_dec, rem_sub;
	logic [2:0]  phase_q, phase_e, phase_n;
	logic [7:0]  kind_q, kind_e, kind_n;
	logic [7:0]  skip_q, skip_e, skip_n, skip_dec, skip_len;
	logic [31:0] label_q, label_e, label_n;
	logic [1:0]  seen_q, seen_e, seen_n;
	logic [5:0]  len_sat;
	logic [7:0]  b;

	assign b = item.option_byte;
	assign len_sat = (item.area_length > tole_pkg::AREA_MAX) ? tole_pkg::AREA_MAX
		: item.area_length;
	assign rem_dec = rem_e - 6'd1;
	assign rem_sub = rem_e - b[5:0];
	assign skip_dec = skip_e - 8'd1;
	assign skip_len = b - tole_pkg::MIN_OPT_LEN;

	always_comb begin
		// Restart on the first byte of a segment.
		if (item.first_of_segment) begin
			rem_e = len_sat;
			kind_e = '0;
			skip_e = '0;
			label_e = '0;
			seen_e = '0;
			phase_e = (len_sat == 6'd0) ? tole_pkg::PH_DONE : tole_pkg::PH_KIND;
		end else begin
			rem_e = rem_q;
			kind_e = kind_q;
			skip_e = skip_q;
			label_e = label_q;
			seen_e = seen_q;
			phase_e = phase_q;
		end

		rem_n = rem_e;
		kind_n = kind_e;
		skip_n = skip_e;
		label_n = label_e;
		seen_n = seen_e;
		phase_n = phase_e;
		result = '0;

		if (item.first_of_segment && len_sat == 6'd0) begin
			result.valid = 1'b1;
			result.parse_status = tole_pkg::ST_EXHAUSTED;
		end

		unique case (phase_e)
			tole_pkg::PH_KIND: begin
				if (b == tole_pkg::KIND_END) begin
					result.valid = 1'b1;
					result.parse_status = tole_pkg::ST_EOL;
					phase_n = tole_pkg::PH_DONE;
				end else if (b == tole_pkg::KIND_NOP) begin
					rem_n = rem_dec;
					if (rem_dec == 6'd0) begin
						result.valid = 1'b1;
						result.parse_status = tole_pkg::ST_EXHAUSTED;
						phase_n = tole_pkg::PH_DONE;
					end
				end else begin
					kind_n = b;
					if (rem_e <= 6'd1) begin
						result.valid = 1'b1;
						result.parse_status = tole_pkg::ST_PARTIAL;
						phase_n = tole_pkg::PH_DONE;
					end else begin
						phase_n = tole_pkg::PH_LEN;
					end
				end
			end
			tole_pkg::PH_LEN: begin
				if (b < tole_pkg::MIN_OPT_LEN) begin
					result.valid = 1'b1;
					result.parse_status = tole_pkg::ST_SILLY;
					phase_n = tole_pkg::PH_DONE;
				end else if (b > {2'b00, rem_e}) begin
					result.valid = 1'b1;
					result.parse_status = tole_pkg::ST_PARTIAL;
					phase_n = tole_pkg::PH_DONE;
				end else if (kind_e == label_kind && b == tole_pkg::LABEL_OPT_LEN) begin
					label_n = '0;
					seen_n = '0;
					phase_n = tole_pkg::PH_LABEL;
				end else begin
					rem_n = rem_sub;
					skip_n = skip_len;
					if (skip_len != 8'd0) begin
						phase_n = tole_pkg::PH_SKIP;
					end else if (rem_sub == 6'd0) begin
						result.valid = 1'b1;
						result.parse_status = tole_pkg::ST_EXHAUSTED;
						phase_n = tole_pkg::PH_DONE;
					end else begin
						phase_n = tole_pkg::PH_KIND;
					end
				end
			end
			tole_pkg::PH_SKIP: begin
				skip_n = skip_dec;
				if (skip_dec == 8'd0) begin
					if (rem_e == 6'd0) begin
						result.valid = 1'b1;
						result.parse_status = tole_pkg::ST_EXHAUSTED;
						phase_n = tole_pkg::PH_DONE;
					end else begin
						phase_n = tole_pkg::PH_KIND;
					end
				end
			end
			tole_pkg::PH_LABEL: begin
				label_n = {label_e[23:0], b};
				if (seen_e == tole_pkg::LABEL_LAST_BYTE) begin
					seen_n = '0;
					result.valid = 1'b1;
					result.label_value = {label_e[23:0], b};
					result.parse_status = tole_pkg::ST_FOUND;
					phase_n = tole_pkg::PH_DONE;
				end else begin
					seen_n = seen_e + 2'd1;
				end
			end
			default: begin
				// Done: ignore bytes until the next segment.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			phase_q <= tole_pkg::PH_DONE;
			kind_q <= '0;
			skip_q <= '0;
			label_q <= '0;
			seen_q <= '0;
		end else if (advance) begin
			rem_q <= rem_n;
			phase_q <= phase_n;
			kind_q <= kind_n;
			skip_q <= skip_n;
			label_q <= label_n;
			seen_q <= seen_n;
		end
	end

endmodule

@@ design/tole_out_reg.sv @@
// Result register: holds one result until the receiver takes it.
`timescale 1ns / 1ps

module tole_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  tole_pkg::result_t result,
	output logic              free,
	tole_out_if.source        result_out
);

	logic        valid_q;
	logic [31:0] label_q;
	logic [2:0]  status_q;

	assign free = !valid_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && result.valid) begin
			label_q <= result.label_value;
			status_q <= result.parse_status;
		end
	end

	assign result_out.valid = valid_q;
	assign result_out.label_value = label_q;
	assign result_out.parse_status = status_q;

endmodule

@@ design/tole_checker.sv @@
// Checker: port-level assertions for the TCP option label extractor, with its bind.
`timescale 1ns / 1ps

module tole_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_label,
	input logic [2:0]  out_status
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_status <= tole_pkg::ST_PARTIAL))
		else $error("result status out of range");

	a_label_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_status != tole_pkg::ST_FOUND) |-> (out_label == 32'd0))
		else $error("label nonzero on a result without a label");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while the result side is free");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_label)
			&& $stable(out_status)))
		else $error("stalled result changed");

endmodule

bind tcp_option_label_extractor tole_checker u_tole_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (option_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.out_label  (result_out.label_value),
	.out_status (result_out.parse_status)
);

@@ verif/tb_top.sv @@
// Testbench for the TCP option label extractor: directed and random option areas, scoreboard.
`timescale 1ns / 1ps

module tb_top;
	import tole_pkg::*;

	// One expected outcome of a segment walk
	typedef struct {
		logic [31:0] label;
		logic [2:0]  status;
	} verdict_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	tole_in_if  in_ch ();
	tole_out_if out_ch ();

	tcp_option_label_extractor uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.label_kind_we    (cfg_we),
		.label_kind_wdata (cfg_wdata),
		.option_in        (in_ch),
		.result_out       (out_ch)
	);

	// Stimulus feed, expectation store and the bookkeeping around them
	in_item_t   byte_feed [$];
	in_item_t   feed_item;
	verdict_t   expected_results [$];
	logic [7:0] area [$];
	bit         steady;
	int         errors;
	int         status_tally [5];
	int         kinds_tried;

	// Shadow of the parser state, advanced once per accepted transaction
	logic [7:0]  label_kind;
	logic [5:0]  remaining;
	logic [2:0]  phase;
	logic [7:0]  cur_kind;
	logic [7:0]  skip_left;
	logic [31:0] label_acc;
	logic [1:0]  label_cnt;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hold every input at a known value from time zero
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		in_ch.valid = 1'b0;
		in_ch.option_byte = 8'd0;
		in_ch.first_of_segment = 1'b0;
		in_ch.area_length = 6'd0;
		out_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Safety net: even the slowest correct run ends far earlier
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Close the segment: record its outcome and go back to waiting
	task automatic conclude(input logic [2:0] status, input logic [31:0] label);
		verdict_t v;
		v.label = label;
		v.status = status;
		expected_results.push_back(v);
		status_tally[status]++;
		phase = PH_DONE;
	endtask

	// After an option is passed: next kind byte, or the area is used up
	task automatic next_option();
		if (remaining == 6'd0)
			conclude(ST_EXHAUSTED, 32'd0);
		else
			phase = PH_KIND;
	endtask

	// Advance the shadow walker by one option byte
	task automatic walk_option_byte(input logic [7:0] b, input logic first,
		input logic [5:0] alen);
		logic [5:0] n;
		logic       go;
		n = alen;
		go = 1'b1;
		if (first) begin
			if (n > AREA_MAX)
				n = AREA_MAX;
			remaining = n;
			cur_kind = 8'd0;
			skip_left = 8'd0;
			label_acc = 32'd0;
			label_cnt = 2'd0;
			if (n == 6'd0) begin
				// empty area: decided at once, the byte itself is ignored
				conclude(ST_EXHAUSTED, 32'd0);
				go = 1'b0;
			end else begin
				phase = PH_KIND;
			end
		end
		if (go) begin
			case (phase)
				PH_KIND: begin
					if (b == KIND_END) begin
						conclude(ST_EOL, 32'd0);
					end else if (b == KIND_NOP) begin
						remaining = remaining - 6'd1;
						next_option();
					end else begin
						cur_kind = b;
						// a kind byte with nothing after it in the area
						if (remaining <= 6'd1)
							conclude(ST_PARTIAL, 32'd0);
						else
							phase = PH_LEN;
					end
				end
				PH_LEN: begin
					if (b < MIN_OPT_LEN) begin
						conclude(ST_SILLY, 32'd0);
					end else if (b > {2'b00, remaining}) begin
						conclude(ST_PARTIAL, 32'd0);
					end else if (cur_kind == label_kind && b == LABEL_OPT_LEN) begin
						label_acc = 32'd0;
						label_cnt = 2'd0;
						phase = PH_LABEL;
					end else begin
						remaining = remaining - b[5:0];
						skip_left = b - MIN_OPT_LEN;
						if (skip_left == 8'd0)
							next_option();
						else
							phase = PH_SKIP;
					end
				end
				PH_SKIP: begin
					skip_left = skip_left - 8'd1;
					if (skip_left == 8'd0)
						next_option();
				end
				PH_LABEL: begin
					label_acc = {label_acc[23:0], b};
					if (label_cnt == LABEL_LAST_BYTE) begin
						label_cnt = 2'd0;
						conclude(ST_FOUND, label_acc);
					end else begin
						label_cnt = label_cnt + 2'd1;
					end
				end
				default: ;
			endcase
		end
	endtask

	// Driver: present the next pending byte once the previous one is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (byte_feed.size() != 0 && (steady || $urandom_range(0, 99) >= 7)) begin
				feed_item = byte_feed.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.option_byte <= feed_item.option_byte;
				in_ch.first_of_segment <= feed_item.first_of_segment;
				in_ch.area_length <= feed_item.area_length;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result sink: stall now and then, never during the steady stretch
	always @(posedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= steady || ($urandom_range(0, 99) >= 7);
	end

	// Monitor: predict on each input transaction, check each result transaction
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				walk_option_byte(in_ch.option_byte, in_ch.first_of_segment,
					in_ch.area_length);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					report($sformatf("result with nothing expected: status %0d label %h",
						out_ch.parse_status, out_ch.label_value));
				end else begin
					want = expected_results.pop_front();
					if (out_ch.parse_status !== want.status)
						report($sformatf("parse_status %0d, expected %0d",
							out_ch.parse_status, want.status));
					if (out_ch.label_value !== want.label)
						report($sformatf("label_value %h, expected %h",
							out_ch.label_value, want.label));
				end
			end
		end
	end

	// Queue one byte; the area length field only matters on a first byte
	task automatic push_byte(input logic [7:0] b, input logic first, input logic [5:0] alen);
		in_item_t it;
		it.option_byte = b;
		it.first_of_segment = first;
		it.area_length = first ? alen : 6'($urandom_range(0, 63));
		byte_feed.push_back(it);
	endtask

	// Queue the bytes held in area as one segment
	task automatic send_area(input logic [5:0] alen);
		push_byte(area.size() != 0 ? area[0] : 8'($urandom), 1'b1, alen);
		for (int i = 1; i < area.size(); i++)
			push_byte(area[i], 1'b0, 6'd0);
	endtask

	// Wait until the block has gone quiet with nothing outstanding
	task automatic drain();
		while (byte_feed.size() != 0 || in_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_label_kind(input logic [7:0] v);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		label_kind = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		kinds_tried++;
		@(negedge clk);
	endtask

	// Fill area with an option list: mostly well formed, sometimes raw noise
	task automatic build_area(input int len, input bit noisy);
		int r;
		int olen;
		area.delete();
		while (area.size() < len) begin
			r = $urandom_range(0, 99);
			if (noisy) begin
				area.push_back(r < 50 ? 8'($urandom_range(0, 8)) : 8'($urandom));
			end else if (r < 20) begin
				area.push_back(KIND_NOP);
			end else if (r < 25) begin
				// end of list, then trailing garbage up to the area length
				area.push_back(KIND_END);
				while (area.size() < len)
					area.push_back(8'($urandom));
			end else if (r < 55) begin
				area.push_back(label_kind);
				area.push_back(LABEL_OPT_LEN);
				r = $urandom_range(0, 9);
				for (int i = 0; i < 4; i++)
					area.push_back(r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom));
			end else begin
				area.push_back(8'($urandom_range(2, 255)));
				olen = $urandom_range(2, 10);
				area.push_back(8'(olen));
				for (int i = 2; i < olen; i++)
					area.push_back(8'($urandom));
			end
		end
	endtask

	// Random segments until about target bytes were actually walked
	task automatic queue_random_segments(input int target);
		int walked;
		int alen;
		int eff;
		int cut;
		walked = 0;
		while (walked < target) begin
			case ($urandom_range(0, 19))
				0: alen = 0;
				1: alen = $urandom_range(41, 63);
				default: alen = $urandom_range(1, 40);
			endcase
			eff = alen > 40 ? 40 : alen;
			build_area(eff, $urandom_range(0, 99) < 15);
			if (area.size() > 1 && $urandom_range(0, 99) < 5) begin
				// drop the tail: the next first byte restarts mid-walk
				cut = $urandom_range(1, area.size() - 1);
				while (area.size() > cut)
					void'(area.pop_back());
			end else begin
				repeat ($urandom_range(0, 2))
					area.push_back(8'($urandom));
			end
			send_area(6'(alen));
			walked += (eff == 0) ? 1 : (area.size() < eff ? area.size() : eff);
		end
	endtask

	initial begin
		steady = 1'b0;
		errors = 0;
		kinds_tried = 1;
		label_kind = LABEL_KIND_RESET;
		remaining = 6'd0;
		phase = PH_DONE;
		cur_kind = 8'd0;
		skip_left = 8'd0;
		label_acc = 32'd0;
		label_cnt = 2'd0;
		foreach (status_tally[i])
			status_tally[i] = 0;
		@(posedge arst_n);
		@(negedge clk);

		// Directed: label kind at its reset value
		push_byte(8'h53, 1'b0, 6'd12);       // stray byte before any segment
		area = '{8'h5A};
		send_area(6'd0);                     // empty area
		area = '{8'd83, 8'd6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0};
		send_area(6'd63);                    // oversized length saturates
		area = '{8'd83, 8'd6, 8'h00, 8'h00, 8'h00, 8'h00};
		send_area(6'd6);
		area = '{8'd5};
		send_area(6'd1);                     // lone kind byte
		area = '{8'd7, 8'd1};
		send_area(6'd4);                     // silly length
		area = '{8'd7, 8'd5};
		send_area(6'd4);                     // option runs past the area
		area = '{8'd1, 8'd1, 8'd1};
		send_area(6'd3);                     // NOPs use up the area
		area = '{8'd0};
		send_area(6'd4);                     // end of list
		area = '{8'd83, 8'd6, 8'hAA};
		send_area(6'd10);                    // abandoned by the next first byte
		area = '{8'd9, 8'd2};
		send_area(6'd2);

		// Random phases across label kinds, the extremes among them
		queue_random_segments(300);
		set_label_kind(8'd255);
		steady = 1'b1;
		queue_random_segments(300);
		drain();
		steady = 1'b0;
		set_label_kind(8'd0);
		queue_random_segments(250);
		set_label_kind(8'd1);
		queue_random_segments(150);
		set_label_kind(8'($urandom_range(2, 254)));
		queue_random_segments(350);
		set_label_kind(LABEL_KIND_RESET);
		queue_random_segments(350);

		drain();
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0)
			report($sformatf("%0d results never arrived", expected_results.size()));
		$display("Walked segments under %0d label kinds: %0d found, %0d end-of-list,",
			kinds_tried, status_tally[ST_FOUND], status_tally[ST_EOL]);
		$display("  %0d exhausted, %0d silly length, %0d partial; %0d mismatches.",
			status_tally[ST_EXHAUSTED], status_tally[ST_SILLY], status_tally[ST_PARTIAL],
			errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
